FILE: hdl/stp_pkg.sv
// Shared constants and types for the spanning-tree configuration message update block.
`timescale 1ns / 1ps

package stp_pkg;

  // Default sizes of the bridge.
  localparam int NUM_PORTS_DEF = 16;
  localparam int ID_BITS_DEF   = 64;
  localparam int DIST_BITS_DEF = 8;

  // Fixed widths of the external fields.
  localparam int PORT_IDX_W = 4;
  localparam int ID_FIELD_W = 64;
  localparam int DIST_FIELD_W = 8;
  localparam int MAP_FIELD_W = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_NONE    = 2'd0,
    STATUS_CHANGED = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_BRIDGE_ID = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PORTS_PRESENT = 1'd1;

endpackage

FILE: hdl/spanning_tree_bpdu_update.sv
// Spanning-tree configuration message processing for one bridge.
// An accepted request passes through the input register and then the result register.
// Throughput: one request per cycle while no held result stalls it; the bridge state update is
// one short compare-and-select pass between the input register and the state and result registers.
// Reset (rst, synchronous, active high) empties both stages, clears the root, distance and
// root port, designates every port that fits the 16-bit map field and unblocks all ports.
`timescale 1ns / 1ps

module spanning_tree_bpdu_update #(
  parameter int NUM_PORTS = stp_pkg::NUM_PORTS_DEF,
  parameter int ID_BITS   = stp_pkg::ID_BITS_DEF,
  parameter int DIST_BITS = stp_pkg::DIST_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_write,
  input  logic [stp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]       cfg_data,
  // Request channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [stp_pkg::PORT_IDX_W-1:0]       arrival_port,
  input  logic [stp_pkg::ID_FIELD_W-1:0]       adv_root_id,
  input  logic [stp_pkg::DIST_FIELD_W-1:0]     adv_distance,
  input  logic [stp_pkg::ID_FIELD_W-1:0]       adv_sender_id,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [stp_pkg::ID_FIELD_W-1:0]       cur_root_id,
  output logic [stp_pkg::DIST_FIELD_W-1:0]     cur_distance,
  output logic [stp_pkg::PORT_IDX_W-1:0]       cur_root_port,
  output logic                                 root_port_valid,
  output logic [stp_pkg::MAP_FIELD_W-1:0]      designated_ports,
  output logic [stp_pkg::MAP_FIELD_W-1:0]      blocked_ports
);

  // Number of map bits that reach the 16-bit port fields, and of distance bits
  // that come from the 8-bit distance field.
  localparam int MW = (NUM_PORTS < stp_pkg::MAP_FIELD_W) ? NUM_PORTS : stp_pkg::MAP_FIELD_W;
  localparam int DW = (DIST_BITS < stp_pkg::DIST_FIELD_W) ? DIST_BITS : stp_pkg::DIST_FIELD_W;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
  localparam logic [NUM_PORTS-1:0] ONE_PORT = NUM_PORTS'(1);

  // Configuration.
  logic [ID_BITS-1:0] own_id;

  // Bridge state.
  logic                         root_learned;
  logic [ID_BITS-1:0]           best_root;
  logic [DIST_BITS-1:0]         root_distance;
  logic [ID_BITS-1:0]           best_sender;
  logic [stp_pkg::PORT_IDX_W-1:0] root_idx;
  logic                         has_root_port;
  logic [NUM_PORTS-1:0]         designated_map;
  logic [NUM_PORTS-1:0]         blocked_map;

  // Input register, holding the request with its fields already masked.
  logic                         s1_valid;
  logic [stp_pkg::PORT_IDX_W-1:0] s1_port;
  logic [ID_BITS-1:0]           s1_root;
  logic [DIST_BITS-1:0]         s1_dist;
  logic [ID_BITS-1:0]           s1_sender;

  logic in_accept;
  logic advance;

  // The compute stage moves forward whenever the result register is free or drained.
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_port   <= arrival_port;
      s1_root   <= adv_root_id[ID_BITS-1:0];
      s1_dist   <= DIST_BITS'(adv_distance[DW-1:0]);
      s1_sender <= adv_sender_id[ID_BITS-1:0];
    end
  end

  // Next-state logic: one message against the current bridge state.
  logic [ID_BITS-1:0]             cur_root;
  logic [ID_BITS-1:0]             cur_send;
  logic [NUM_PORTS-1:0]           port_bit;
  logic                           port_in_range;
  logic                           is_root_port;
  logic                           port_ok;
  logic [DIST_BITS:0]             d1;
  logic [DIST_BITS:0]             rd_ext;
  logic [DIST_BITS-1:0]           d1_sat;
  logic                           do_block;
  logic                           move_req;
  logic                           move_to_blocked;
  logic                           do_fix;

  logic                           root_learned_next;
  logic [ID_BITS-1:0]             best_root_next;
  logic [DIST_BITS-1:0]           root_distance_next;
  logic [ID_BITS-1:0]             best_sender_next;
  logic [stp_pkg::PORT_IDX_W-1:0] root_idx_next;
  logic                           has_root_port_next;
  logic [NUM_PORTS-1:0]           designated_map_next;
  logic [NUM_PORTS-1:0]           blocked_map_next;
  stp_pkg::status_t               status_next;

  always_comb begin
    cur_root      = root_learned ? best_root : own_id;
    cur_send      = root_learned ? best_sender : own_id;
    port_in_range = (32'(s1_port) < NUM_PORTS);
    port_bit      = port_in_range ? (ONE_PORT << s1_port) : '0;
    is_root_port  = has_root_port && (root_idx == s1_port);
    port_ok       = port_in_range && (((designated_map & port_bit) != '0) || is_root_port);
    d1            = {1'b0, s1_dist} + (DIST_BITS+1)'(1);
    rd_ext        = {1'b0, root_distance};
    d1_sat        = d1[DIST_BITS] ? DIST_MAX : d1[DIST_BITS-1:0];

    root_learned_next   = root_learned;
    best_root_next      = best_root;
    root_distance_next  = root_distance;
    best_sender_next    = best_sender;
    root_idx_next       = root_idx;
    has_root_port_next  = has_root_port;
    designated_map_next = designated_map;
    blocked_map_next    = blocked_map;
    status_next         = stp_pkg::STATUS_NONE;
    do_block            = 1'b0;
    move_req            = 1'b0;
    move_to_blocked     = 1'b0;
    do_fix              = 1'b0;

    if (!port_ok) begin
      status_next = stp_pkg::STATUS_INVALID;
    end else if (s1_root < cur_root) begin
      // A better root: adopt it, the old root port becomes designated.
      root_distance_next = d1_sat;
      best_root_next     = s1_root;
      best_sender_next   = s1_sender;
      root_learned_next  = 1'b1;
      move_req           = 1'b1;
      status_next        = stp_pkg::STATUS_CHANGED;
    end else if (s1_root == cur_root) begin
      if ((d1 < rd_ext) || ((d1 == rd_ext) && (s1_sender < cur_send))) begin
        // Same root over a better path: the old root port is blocked.
        root_distance_next = d1_sat;
        best_root_next     = cur_root;
        best_sender_next   = s1_sender;
        root_learned_next  = 1'b1;
        move_req           = 1'b1;
        move_to_blocked    = 1'b1;
        status_next        = stp_pkg::STATUS_CHANGED;
      end else if (d1 == rd_ext) begin
        do_block = 1'b1;
      end else if ((s1_dist == root_distance) && (own_id > s1_sender)) begin
        do_block = 1'b1;
      end
    end

    if (move_req) begin
      do_fix = 1'b1;
      if (!is_root_port) begin
        if (has_root_port) begin
          if (move_to_blocked) begin
            blocked_map_next = blocked_map_next | (ONE_PORT << root_idx);
          end else begin
            designated_map_next = designated_map_next | (ONE_PORT << root_idx);
          end
        end
        root_idx_next       = s1_port;
        has_root_port_next  = 1'b1;
        designated_map_next = designated_map_next & ~port_bit;
      end
    end

    // A tie only blocks a port that is still designated.
    if (do_block && ((designated_map & port_bit) != '0)) begin
      designated_map_next = designated_map_next & ~port_bit;
      blocked_map_next    = blocked_map_next | port_bit;
      do_fix              = 1'b1;
      status_next         = stp_pkg::STATUS_CHANGED;
    end

    // A bridge with nothing left to serve gives up its root port.
    if (do_fix && (designated_map_next == '0) && has_root_port_next) begin
      blocked_map_next   = blocked_map_next | (ONE_PORT << root_idx_next);
      has_root_port_next = 1'b0;
      root_idx_next      = '0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_id         <= '0;
      root_learned   <= 1'b0;
      root_distance  <= '0;
      root_idx       <= '0;
      has_root_port  <= 1'b0;
      designated_map <= NUM_PORTS'({MW{1'b1}});
      blocked_map    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        stp_pkg::REG_OWN_BRIDGE_ID: begin
          own_id <= cfg_data[ID_BITS-1:0];
        end
        stp_pkg::REG_PORTS_PRESENT: begin
          designated_map <= NUM_PORTS'(cfg_data[MW-1:0]);
        end
        default: begin
        end
      endcase
    end else if (advance) begin
      root_learned   <= root_learned_next;
      root_distance  <= root_distance_next;
      root_idx       <= root_idx_next;
      has_root_port  <= has_root_port_next;
      designated_map <= designated_map_next;
      blocked_map    <= blocked_map_next;
    end
  end

  // The learned root and sender are only read once root_learned is set.
  always_ff @(posedge clk) begin
    if (advance) begin
      best_root   <= best_root_next;
      best_sender <= best_sender_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status           <= status_next;
      cur_root_id      <= stp_pkg::ID_FIELD_W'(root_learned_next ? best_root_next : own_id);
      cur_distance     <= stp_pkg::DIST_FIELD_W'(root_distance_next);
      cur_root_port    <= has_root_port_next ? root_idx_next : '0;
      root_port_valid  <= has_root_port_next;
      designated_ports <= stp_pkg::MAP_FIELD_W'(designated_map_next[MW-1:0]);
      blocked_ports    <= stp_pkg::MAP_FIELD_W'(blocked_map_next[MW-1:0]);
    end
  end

  // Without a root port the stored index is always cleared.
  a_no_root_port_idx: assert property (@(posedge clk) disable iff (rst)
    !has_root_port |-> (root_idx == '0))
    else $error("root port index set while no root port exists");

  // The input side only waits on a full result register that is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a held result");

  // Every request that leaves the input register shows up as a result.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("computed request produced no result");

  // An invalid-port message leaves the port state untouched.
  a_invalid_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (advance && !port_ok && !cfg_write) |=>
      (designated_map == $past(designated_map)) && (blocked_map == $past(blocked_map)) &&
      (has_root_port == $past(has_root_port)))
    else $error("invalid-port message changed the port state");

endmodule
